// ----- rtl/fpba_pkg.sv -----
`timescale 1ns / 1ps

package fpba_pkg;

  // table geometry
  localparam int NUM_BLOCKS = 8;
  localparam int SIZE_WIDTH = 16;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int POL_W      = 2;
  localparam int LIM_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd1;

  // fit policy codes, the unused code behaves as first fit
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic [POL_W-1:0] POL_RESET = POL_FIRST;
  localparam logic [LIM_W-1:0] LIM_RESET = 4'd8;

  // item operations
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [2:0]            block_index;
    logic [SIZE_WIDTH-1:0] size_value;
  } in_item_t;

  typedef struct packed {
    logic                  granted;
    logic [2:0]            chosen_block;
    logic [SIZE_WIDTH-1:0] remaining_size;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_wr;
    logic start;
    logic scan_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

// ----- rtl/fpba_ctrl.sv -----
`timescale 1ns / 1ps

module fpba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fpba_pkg::status_t status,
  output fpba_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;

  // handshake
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // commands to the datapath
  always_comb begin
    cmd.load_wr   = accept && (in_op == fpba_pkg::OP_LOAD);
    cmd.start     = accept && (in_op == fpba_pkg::OP_ALLOC);
    cmd.scan_step = (state_r == ST_SCAN) && !status.scan_done;
    cmd.finish    = (state_r == ST_UPDATE) && slot_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result register occupancy
  assign out_valid_nxt = cmd.finish ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/fpba_dp.sv -----
`timescale 1ns / 1ps

module fpba_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fpba_pkg::in_item_t                  in_data,
  output fpba_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  fpba_pkg::cmd_t                      cmd,
  output fpba_pkg::status_t                   status
);

  logic [fpba_pkg::SIZE_WIDTH-1:0] tbl_r [fpba_pkg::NUM_BLOCKS];
  logic [fpba_pkg::POL_W-1:0]      policy_r;
  logic [fpba_pkg::LIM_W-1:0]      in_use_r;
  logic [fpba_pkg::SIZE_WIDTH-1:0] req_r;
  logic [fpba_pkg::CNT_W-1:0]      cnt_r;
  logic                            found_r;
  logic [fpba_pkg::IDX_W-1:0]      pick_r;
  logic [fpba_pkg::SIZE_WIDTH-1:0] best_r;
  fpba_pkg::out_item_t             out_r;

  logic [fpba_pkg::CNT_W-1:0]      limit;
  logic [fpba_pkg::SIZE_WIDTH-1:0] entry;
  logic [fpba_pkg::SIZE_WIDTH-1:0] left;
  logic                            fits;
  logic                            take;

  // search limit, saturated to the table depth
  always_comb begin
    if ({{(fpba_pkg::CNT_W){1'b0}}, in_use_r} > (fpba_pkg::CNT_W + fpba_pkg::LIM_W)'(fpba_pkg::NUM_BLOCKS))
      limit = fpba_pkg::CNT_W'(fpba_pkg::NUM_BLOCKS);
    else
      limit = fpba_pkg::CNT_W'(in_use_r);
  end

  assign status.scan_done = (cnt_r >= limit);

  // one compare per cycle over the table
  assign entry = tbl_r[cnt_r[fpba_pkg::IDX_W-1:0]];
  assign fits  = (entry >= req_r);

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        unique case (policy_r)
          fpba_pkg::POL_BEST:  take = (entry < best_r);
          fpba_pkg::POL_WORST: take = (entry > best_r);
          default:             take = 1'b0;
        endcase
      end
    end
  end

  assign left = best_r - req_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpba_pkg::POL_RESET;
      in_use_r <= fpba_pkg::LIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fpba_pkg::REG_FIT_POLICY:    policy_r <= cfg_wdata[fpba_pkg::POL_W-1:0];
        fpba_pkg::REG_BLOCKS_IN_USE: in_use_r <= cfg_wdata[fpba_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // free size table: load writes and grant write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < fpba_pkg::NUM_BLOCKS; k++) begin
        tbl_r[k] <= '0;
      end
    end else if (cmd.load_wr) begin
      tbl_r[in_data.block_index[fpba_pkg::IDX_W-1:0]] <= in_data.size_value;
    end else if (cmd.finish && found_r) begin
      tbl_r[pick_r] <= left;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.start) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (take) found_r <= 1'b1;
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r <= in_data.size_value;
    end
    if (cmd.scan_step && take) begin
      pick_r <= cnt_r[fpba_pkg::IDX_W-1:0];
      best_r <= entry;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.granted        <= found_r;
      out_r.chosen_block   <= found_r ? 3'(pick_r) : 3'd0;
      out_r.remaining_size <= found_r ? left : '0;
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/fit_policy_block_allocator.sv -----
`timescale 1ns / 1ps

// load item: written into the free size table, no result; next item may follow at once
// allocate item: accept, one search step per searched block (blocks_in_use, at most 8),
// then closing the search, then the write-back; in_stall holds new items off until then
// the result is registered at the write-back and stays valid while out_stall holds it
// reset (synchronous, rst_n low) clears the free size table to zero,
// sets fit_policy to first fit and blocks_in_use to 8
module fit_policy_block_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fpba_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fpba_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  fpba_pkg::cmd_t    cmd;
  fpba_pkg::status_t status;

  // sequencer
  fpba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // table, search and result
  fpba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fpba_pkg::*;

  // the policy code that the block treats as first fit
  localparam logic [POL_W-1:0] POL_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_SETTING = 68;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // one row of the directed table: a register write or an item
  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              item;
    bit                    known;
    out_item_t             want;
  } dir_row_t;

  // free size table and settings as the block should hold them
  logic [SIZE_WIDTH-1:0] free_tbl [NUM_BLOCKS];
  logic [POL_W-1:0]      pol_now = POL_RESET;
  logic [LIM_W-1:0]      lim_now = LIM_RESET;

  out_item_t awaited[$];
  dir_row_t  dir_rows[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int items_sent = 0;
  int allocs_sent = 0;
  int grants_seen = 0;
  int refusals_seen = 0;
  int reg_writes = 0;

  fit_policy_block_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fit_policy_block_allocator verification failed");
      $finish;
    end
  end

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
  endtask

  // apply one item to the table; returns 1 when the item yields a result
  function automatic bit step_free_table(input in_item_t it, output out_item_t res);
    int               n;
    logic [IDX_W-1:0] pick;
    bit               found;
    pick = '0;
    found = 1'b0;
    res = '0;
    if (it.op == OP_LOAD) begin
      free_tbl[it.block_index] = it.size_value;
      return 1'b0;
    end
    n = (lim_now > NUM_BLOCKS) ? NUM_BLOCKS : int'(lim_now);
    for (int k = 0; k < n; k++) begin
      if (free_tbl[IDX_W'(k)] >= it.size_value) begin
        if (!found) begin
          found = 1'b1;
          pick = IDX_W'(k);
        end else if (pol_now == POL_BEST && free_tbl[IDX_W'(k)] < free_tbl[pick]) begin
          pick = IDX_W'(k);
        end else if (pol_now == POL_WORST && free_tbl[IDX_W'(k)] > free_tbl[pick]) begin
          pick = IDX_W'(k);
        end
      end
    end
    if (found) begin
      free_tbl[pick] = free_tbl[pick] - it.size_value;
      res.granted = 1'b1;
      res.chosen_block = 3'(pick);
      res.remaining_size = free_tbl[pick];
    end
    return 1'b1;
  endfunction

  // offer one item; on transfer update the table and queue what it yields
  task automatic send_item(input in_item_t it, input bit known, input out_item_t want);
    out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
    if (it.op == OP_ALLOC) allocs_sent++;
    if (step_free_table(it, res)) awaited.push_back(known ? want : res);
    @(negedge clk);
  endtask

  // stop offering and let the block settle with nothing outstanding
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    if (sel == REG_FIT_POLICY) pol_now = val[POL_W-1:0];
    else lim_now = val[LIM_W-1:0];
    reg_writes++;
  endtask

  // directed table rows
  function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] sel,
                                       input logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  function automatic dir_row_t load_row(input int blk, input int sz);
    dir_row_t r;
    r = '{default: '0};
    r.item.op = OP_LOAD;
    r.item.block_index = 3'(blk);
    r.item.size_value = SIZE_WIDTH'(sz);
    return r;
  endfunction

  // block_index is set to ones on allocations, the block must ignore it
  function automatic dir_row_t alloc_row(input int sz);
    dir_row_t r;
    r = '{default: '0};
    r.item.op = OP_ALLOC;
    r.item.block_index = 3'd7;
    r.item.size_value = SIZE_WIDTH'(sz);
    return r;
  endfunction

  function automatic dir_row_t alloc_known(input int sz, input bit g, input int blk,
                                           input int rem);
    dir_row_t r;
    r = alloc_row(sz);
    r.known = 1'b1;
    r.want.granted = g;
    r.want.chosen_block = 3'(blk);
    r.want.remaining_size = SIZE_WIDTH'(rem);
    return r;
  endfunction

  // sizes biased towards small values and the extremes
  function automatic logic [SIZE_WIDTH-1:0] random_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return SIZE_WIDTH'($urandom_range(63));
      5, 6:    return SIZE_WIDTH'($urandom_range(4095));
      default: return SIZE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.op = ($urandom_range(99) < 35) ? OP_LOAD : OP_ALLOC;
    it.block_index = 3'($urandom_range(NUM_BLOCKS - 1));
    if (it.op == OP_LOAD)
      it.size_value = $urandom_range(1) ? SIZE_WIDTH'($urandom) : random_size();
    else if ($urandom_range(99) < 25)
      // exact fit against a block currently in the table
      it.size_value = free_tbl[IDX_W'($urandom_range(NUM_BLOCKS - 1))];
    else
      it.size_value = random_size();
    return it;
  endfunction

  // receiver: random stall, or a long counted hold when asked
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result check against the oldest awaited result
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (out_data.granted) grants_seen++;
      else refusals_seen++;
      if (awaited.size() == 0) begin
        flag_mismatch("result with nothing awaited", 32'(out_data), '0);
      end else begin
        want = awaited.pop_front();
        if (out_data.granted !== want.granted)
          flag_mismatch("granted", 32'(out_data.granted), 32'(want.granted));
        if (out_data.chosen_block !== want.chosen_block)
          flag_mismatch("chosen_block", 32'(out_data.chosen_block), 32'(want.chosen_block));
        if (out_data.remaining_size !== want.remaining_size)
          flag_mismatch("remaining_size", 32'(out_data.remaining_size),
                        32'(want.remaining_size));
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t  row;
    out_item_t none;
    int        setting;
    none = '0;
    for (int k = 0; k < NUM_BLOCKS; k++) free_tbl[k] = '0;

    // table after reset is all zeros, first fit, all blocks searched
    dir_rows.push_back(alloc_known(0, 1'b1, 0, 0));
    dir_rows.push_back(alloc_known(1, 1'b0, 0, 0));
    dir_rows.push_back(alloc_known(65535, 1'b0, 0, 0));
    dir_rows.push_back(load_row(0, 100));
    dir_rows.push_back(load_row(1, 40));
    dir_rows.push_back(load_row(2, 65535));
    dir_rows.push_back(load_row(3, 40));
    dir_rows.push_back(load_row(4, 200));
    dir_rows.push_back(load_row(5, 0));
    dir_rows.push_back(load_row(6, 65535));
    dir_rows.push_back(load_row(7, 30));
    dir_rows.push_back(alloc_known(35, 1'b1, 0, 65));
    // best fit: exact fit, then a tie between equal blocks
    dir_rows.push_back(reg_row(REG_FIT_POLICY, CFG_DATA_W'(POL_BEST)));
    dir_rows.push_back(alloc_row(30));
    dir_rows.push_back(alloc_row(40));
    // worst fit: tie between the two full blocks goes to the lower one
    dir_rows.push_back(reg_row(REG_FIT_POLICY, CFG_DATA_W'(POL_WORST)));
    dir_rows.push_back(alloc_known(65535, 1'b1, 2, 0));
    dir_rows.push_back(alloc_row(1));
    // unused policy code acts as first fit
    dir_rows.push_back(reg_row(REG_FIT_POLICY, CFG_DATA_W'(POL_UNUSED)));
    dir_rows.push_back(alloc_row(50));
    // nothing searched: even a zero request is refused
    dir_rows.push_back(reg_row(REG_BLOCKS_IN_USE, 4'd0));
    dir_rows.push_back(alloc_known(0, 1'b0, 0, 0));
    // search count beyond the table saturates
    dir_rows.push_back(reg_row(REG_BLOCKS_IN_USE, 4'd15));
    dir_rows.push_back(alloc_row(100));
    // one block searched, request just too big for it
    dir_rows.push_back(reg_row(REG_BLOCKS_IN_USE, 4'd1));
    dir_rows.push_back(reg_row(REG_FIT_POLICY, CFG_DATA_W'(POL_BEST)));
    dir_rows.push_back(alloc_row(16));
    dir_rows.push_back(reg_row(REG_BLOCKS_IN_USE, 4'd8));
    dir_rows.push_back(reg_row(REG_FIT_POLICY, CFG_DATA_W'(POL_FIRST)));
    dir_rows.push_back(load_row(5, 65535));
    dir_rows.push_back(alloc_row(65535));

    // reset
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_reg) begin
        drain();
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        send_item(row.item, row.known, row.known ? row.want : none);
      end
    end

    // random phases: receiver idles, then sender idles, then neither
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 18 : 0;
      for (int ch = 0; ch < 4; ch++) begin
        setting = ph * 4 + ch;
        drain();
        case (setting)
          0: begin
            write_reg(REG_FIT_POLICY, CFG_DATA_W'(POL_FIRST));
            write_reg(REG_BLOCKS_IN_USE, 4'd8);
          end
          1: begin
            write_reg(REG_FIT_POLICY, CFG_DATA_W'(POL_BEST));
            write_reg(REG_BLOCKS_IN_USE, 4'd8);
          end
          2: begin
            write_reg(REG_FIT_POLICY, CFG_DATA_W'(POL_WORST));
            write_reg(REG_BLOCKS_IN_USE, 4'd8);
          end
          3: begin
            write_reg(REG_FIT_POLICY, CFG_DATA_W'(POL_UNUSED));
            write_reg(REG_BLOCKS_IN_USE, 4'd15);
          end
          default: begin
            write_reg(REG_FIT_POLICY, CFG_DATA_W'($urandom_range(3)));
            if ($urandom_range(99) < 75)
              write_reg(REG_BLOCKS_IN_USE, CFG_DATA_W'($urandom_range(NUM_BLOCKS, 1)));
            else
              write_reg(REG_BLOCKS_IN_USE, CFG_DATA_W'($urandom_range(15)));
          end
        endcase
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          // long receiver hold while items keep coming
          if (ph == 2 && ch == 0 && n == 10) hold_req = 1'b1;
          // sender pause until every awaited result is in
          if (ph == 0 && ch == 1 && n == 35) drain();
          send_item(random_item(), 1'b0, none);
        end
      end
    end

    // wind down
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("run covered %0d items, %0d of them allocations, over %0d register writes",
             items_sent, allocs_sent, reg_writes);
    $display("results seen: %0d grants and %0d refusals, %0d mismatches",
             grants_seen, refusals_seen, mismatches);
    if (mismatches == 0) begin
      $display("fit_policy_block_allocator verification clean");
    end else begin
      $display("fit_policy_block_allocator verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fpba_pkg.sv
rtl/fpba_ctrl.sv
rtl/fpba_dp.sv
rtl/fit_policy_block_allocator.sv
tb/tb.sv
